### rtl/ilu_pkg.sv
// Shared constants, types and helpers of the integer LU factorizer.
package ilu_pkg;

  localparam int MAX_DIM   = 4;
  localparam int DIM_W     = 2;
  localparam int CNT_W     = 3;
  localparam int ADDR_W    = 2 * DIM_W;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int CFG_W     = 3;
  localparam int CFG_IDX_W = 1;
  localparam int UW        = 32;
  localparam int LW        = 64;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  localparam logic [LW-1:0] Q_ONE  = 64'h0000_0001_0000_0000;
  localparam logic [LW-1:0] LW_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [LW-1:0] LW_MIN = 64'h8000_0000_0000_0000;

  // Datapath commands.
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_LINIT, OP_URD, OP_SETA, OP_SETB, OP_GSTART, OP_GNEXT,
    OP_PROD, OP_LSTART, OP_LSET, OP_M1START, OP_M1SET, OP_M2START, OP_M2SET,
    OP_URDT, OP_UMUL, OP_UWR, OP_LRD, OP_LDSTART, OP_LDWR, OP_LMSTART,
    OP_LMSET, OP_LAWR, OP_OUT, OP_FAIL
  } op_t;

  // Controller states.
  typedef enum logic [4:0] {
    S_IDLE, S_LINIT, S_PSTART, S_PCHK, S_ZNEXT, S_ZCHK, S_KNEXT, S_BCHK,
    S_GWAIT, S_GCHK, S_LSTART, S_LWAIT, S_M1S, S_M1W, S_M2S, S_M2W,
    S_RUP, S_RUK, S_RUM, S_RUW, S_LD, S_LDS, S_LDW, S_LM, S_LMS, S_LMW,
    S_LAW, S_ORD
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [ADDR_W-1:0] u_addr;
    logic [ADDR_W-1:0] l_addr;
    logic             diag;
    logic [DIM_W-1:0] orow;
    logic [DIM_W-1:0] ocol;
    logic             ml;
    logic             mu;
    logic             olast;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic rd_zero;
    logic y_zero;
    logic mul2_zero;
  } stat_t;

  // Store address of entry (row, col).
  function automatic logic [ADDR_W-1:0] addr_of(logic [CNT_W-1:0] r, logic [CNT_W-1:0] c);
    return {r[DIM_W-1:0], c[DIM_W-1:0]};
  endfunction

  // Out-of-range dimensions are pulled into 1..MAX_DIM.
  function automatic logic [CNT_W-1:0] clamp_dim(logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] d;
    d = v;
    if (d == '0) begin
      d = CNT_W'(1);
    end else if (d > CNT_W'(MAX_DIM)) begin
      d = CNT_W'(MAX_DIM);
    end
    return d;
  endfunction

endpackage

### rtl/integer_lu_factorizer_core.sv
// Integer LU factorizer top level: controller, datapath and their command link.
// Loading takes one element transfer per cycle; busy stays low until the last element.
// After the last element, L is initialized; then each row operation runs a division per gcd step,
// three divisions (lcm, mul1, mul2), the row update and per L row a division (skipped when
// mul2 is zero) plus a multiply, on the serial units.
// Results then stream one per cycle, m*max(m,n) of them, or one status result; the receiver
// cannot stall. Synchronous reset sets both dimensions to 4 and clears the load position.
module integer_lu_factorizer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [ilu_pkg::UW-1:0]   in_element,
  input  logic                            cfg_we,
  input  logic [ilu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ilu_pkg::CFG_W-1:0]       cfg_wdata,
  output logic                            out_strobe,
  output logic [ilu_pkg::DIM_W-1:0]       out_row,
  output logic [ilu_pkg::DIM_W-1:0]       out_col,
  output logic signed [ilu_pkg::LW-1:0]   out_lower_value,
  output logic signed [ilu_pkg::UW-1:0]   out_upper_value,
  output logic                            out_status,
  output logic                            out_last
);

  ilu_pkg::cmd_t  cmd;
  ilu_pkg::stat_t stat;

  ilu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .stat     (stat)
  );

  ilu_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_element     (in_element),
    .out_strobe     (out_strobe),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_lower_value(out_lower_value),
    .out_upper_value(out_upper_value),
    .out_status     (out_status),
    .out_last       (out_last)
  );

endmodule

### rtl/ilu_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module ilu_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ilu_pkg::LW-1:0]   dividend,
  input  logic [ilu_pkg::UW-1:0]   divisor,
  output logic                     done,
  output logic [ilu_pkg::LW-1:0]   quotient,
  output logic [ilu_pkg::UW-1:0]   remainder
);

  logic                   run_r;
  logic                   fin_r;
  logic                   done_r;
  logic [5:0]             cnt_r;
  logic [ilu_pkg::LW-1:0] quo_r;
  logic [ilu_pkg::UW-1:0] rem_r;
  logic [ilu_pkg::UW-1:0] dvs_r;
  logic                   neg_q_r;
  logic                   neg_r_r;
  logic                   zero_r;
  logic                   ovf_r;
  logic [ilu_pkg::LW-1:0] q_out_r;
  logic [ilu_pkg::UW-1:0] r_out_r;
  logic [ilu_pkg::UW:0]   rem_sh;
  logic                   ge;
  logic [ilu_pkg::UW:0]   rem_n;

  // Restoring step on magnitudes.
  always_comb begin
    rem_sh = {rem_r, quo_r[ilu_pkg::LW-1]};
    ge     = rem_sh >= {1'b0, dvs_r};
    rem_n  = ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
  end

  // Control sequencing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end
    end
  end

  // Operand magnitudes, iteration and sign correction.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r   <= dividend[ilu_pkg::LW-1] ? -dividend : dividend;
      dvs_r   <= divisor[ilu_pkg::UW-1] ? -divisor : divisor;
      rem_r   <= '0;
      neg_q_r <= dividend[ilu_pkg::LW-1] ^ divisor[ilu_pkg::UW-1];
      neg_r_r <= dividend[ilu_pkg::LW-1];
      zero_r  <= divisor == '0;
      ovf_r   <= (dividend == ilu_pkg::LW_MIN) && (divisor == '1);
    end else if (run_r) begin
      quo_r <= {quo_r[ilu_pkg::LW-2:0], ge};
      rem_r <= rem_n[ilu_pkg::UW-1:0];
    end
    if (fin_r) begin
      if (zero_r) begin
        q_out_r <= '0;
        r_out_r <= '0;
      end else begin
        q_out_r <= ovf_r ? ilu_pkg::LW_MAX : (neg_q_r ? -quo_r : quo_r);
        r_out_r <= neg_r_r ? -rem_r : rem_r;
      end
    end
  end

  assign done      = done_r;
  assign quotient  = q_out_r;
  assign remainder = r_out_r;

endmodule

### rtl/ilu_mul.sv
// Shift-add multiplier of a 64-bit by a 32-bit signed value, saturating to 64 bits.
module ilu_mul (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [ilu_pkg::LW-1:0] multiplicand,
  input  logic [ilu_pkg::UW-1:0] multiplier,
  output logic                   done,
  output logic [ilu_pkg::LW-1:0] product
);

  localparam int PW = ilu_pkg::LW + ilu_pkg::UW;

  logic                   run_r;
  logic                   fin_r;
  logic                   done_r;
  logic [4:0]             cnt_r;
  logic [PW-1:0]          prod_r;
  logic [ilu_pkg::LW-1:0] mag_r;
  logic                   neg_r;
  logic [ilu_pkg::LW-1:0] res_r;
  logic [ilu_pkg::LW:0]   sum;
  logic                   sat;

  // One partial product per cycle into the upper half.
  always_comb begin
    sum = {1'b0, prod_r[PW-1:ilu_pkg::UW]} + (prod_r[0] ? {1'b0, mag_r} : '0);
    sat = (|prod_r[PW-1:ilu_pkg::LW]) ||
          (prod_r[ilu_pkg::LW-1] && (!neg_r || (|prod_r[ilu_pkg::LW-2:0])));
  end

  // Control sequencing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end
    end
  end

  // Magnitude product and saturating sign correction.
  always_ff @(posedge clk) begin
    if (start) begin
      mag_r  <= multiplicand[ilu_pkg::LW-1] ? -multiplicand : multiplicand;
      prod_r <= {{ilu_pkg::LW{1'b0}},
                 (multiplier[ilu_pkg::UW-1] ? -multiplier : multiplier)};
      neg_r  <= multiplicand[ilu_pkg::LW-1] ^ multiplier[ilu_pkg::UW-1];
    end else if (run_r) begin
      prod_r <= {sum, prod_r[ilu_pkg::UW-1:1]};
    end
    if (fin_r) begin
      if (sat) begin
        res_r <= neg_r ? ilu_pkg::LW_MIN : ilu_pkg::LW_MAX;
      end else begin
        res_r <= neg_r ? -prod_r[ilu_pkg::LW-1:0] : prod_r[ilu_pkg::LW-1:0];
      end
    end
  end

  assign done    = done_r;
  assign product = res_r;

endmodule

### rtl/ilu_dp.sv
// Datapath: U and L stores, gcd and multiplier registers, arithmetic units, result registers.
module ilu_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ilu_pkg::cmd_t                 cmd,
  output ilu_pkg::stat_t                stat,
  input  logic signed [ilu_pkg::UW-1:0] in_element,
  output logic                          out_strobe,
  output logic [ilu_pkg::DIM_W-1:0]     out_row,
  output logic [ilu_pkg::DIM_W-1:0]     out_col,
  output logic signed [ilu_pkg::LW-1:0] out_lower_value,
  output logic signed [ilu_pkg::UW-1:0] out_upper_value,
  output logic                          out_status,
  output logic                          out_last
);

  logic [ilu_pkg::UW-1:0] u_mem [ilu_pkg::DEPTH];
  logic [ilu_pkg::LW-1:0] l_mem [ilu_pkg::DEPTH];
  logic [ilu_pkg::UW-1:0] u_rd_r, a_r, b_r, x_r, y_r, prod_r, lcm_r;
  logic [ilu_pkg::UW-1:0] mul1_r, mul2_r, t_r, e_r;
  logic [ilu_pkg::LW-1:0] l_rd_r, lv_r;

  logic                   u_we, u_re, l_we, l_re;
  logic [ilu_pkg::UW-1:0] u_wdata;
  logic [ilu_pkg::LW-1:0] l_wdata;
  logic                   div_start, mul_start;
  logic [ilu_pkg::LW-1:0] div_dvd;
  logic [ilu_pkg::UW-1:0] div_dvs;
  logic                   div_done, mul_done;
  logic [ilu_pkg::LW-1:0] div_quo, mul_res;
  logic [ilu_pkg::UW-1:0] div_rem;
  logic [ilu_pkg::LW-1:0] sum;
  logic                   sum_ovf;
  logic [ilu_pkg::UW-1:0] upd;

  logic                     ov_r, ost_r, olast_r, ml_r, mu_r;
  logic [ilu_pkg::DIM_W-1:0] orow_r, ocol_r;

  ilu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  ilu_mul u_mul (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (mul_start),
    .multiplicand(l_rd_r),
    .multiplier  (mul1_r),
    .done        (mul_done),
    .product     (mul_res)
  );

  // Saturating L accumulation and wrapping row update.
  always_comb begin
    sum     = l_rd_r + lv_r;
    sum_ovf = (l_rd_r[ilu_pkg::LW-1] == lv_r[ilu_pkg::LW-1]) &&
              (sum[ilu_pkg::LW-1] != l_rd_r[ilu_pkg::LW-1]);
    upd     = e_r - ilu_pkg::UW'(mul1_r * t_r);
  end

  // Command decode into store controls and unit operands.
  always_comb begin
    u_we      = 1'b0;
    u_re      = 1'b0;
    l_we      = 1'b0;
    l_re      = 1'b0;
    u_wdata   = in_element;
    l_wdata   = '0;
    div_start = 1'b0;
    mul_start = 1'b0;
    div_dvd   = {{ilu_pkg::UW{x_r[ilu_pkg::UW-1]}}, x_r};
    div_dvs   = y_r;
    unique case (cmd.op)
      ilu_pkg::OP_LOAD:  u_we = 1'b1;
      ilu_pkg::OP_LINIT: begin
        l_we    = 1'b1;
        l_wdata = cmd.diag ? ilu_pkg::Q_ONE : '0;
      end
      ilu_pkg::OP_URD, ilu_pkg::OP_URDT: u_re = 1'b1;
      ilu_pkg::OP_GSTART: div_start = 1'b1;
      ilu_pkg::OP_LSTART: begin
        div_start = 1'b1;
        div_dvd   = {{ilu_pkg::UW{prod_r[ilu_pkg::UW-1]}}, prod_r};
        div_dvs   = x_r;
      end
      ilu_pkg::OP_M1START: begin
        div_start = 1'b1;
        div_dvd   = {{ilu_pkg::UW{lcm_r[ilu_pkg::UW-1]}}, lcm_r};
        div_dvs   = a_r;
      end
      ilu_pkg::OP_M2START: begin
        div_start = 1'b1;
        div_dvd   = {{ilu_pkg::UW{lcm_r[ilu_pkg::UW-1]}}, lcm_r};
        div_dvs   = b_r;
      end
      ilu_pkg::OP_UWR: begin
        u_we    = 1'b1;
        u_wdata = upd;
      end
      ilu_pkg::OP_LRD, ilu_pkg::OP_LMSET: l_re = 1'b1;
      ilu_pkg::OP_LDSTART: begin
        div_start = 1'b1;
        div_dvd   = l_rd_r;
        div_dvs   = mul2_r;
      end
      ilu_pkg::OP_LDWR: begin
        l_we    = 1'b1;
        l_wdata = div_quo;
      end
      ilu_pkg::OP_LMSTART: mul_start = 1'b1;
      ilu_pkg::OP_LAWR: begin
        l_we    = 1'b1;
        l_wdata = sum_ovf ? (l_rd_r[ilu_pkg::LW-1] ? ilu_pkg::LW_MIN : ilu_pkg::LW_MAX) : sum;
      end
      ilu_pkg::OP_OUT: begin
        u_re = 1'b1;
        l_re = 1'b1;
      end
      default: ;
    endcase
  end

  // Stores with registered read data.
  always_ff @(posedge clk) begin
    if (u_we) begin
      u_mem[cmd.u_addr] <= u_wdata;
    end
    if (u_re) begin
      u_rd_r <= u_mem[cmd.u_addr];
    end
    if (l_we) begin
      l_mem[cmd.l_addr] <= l_wdata;
    end
    if (l_re) begin
      l_rd_r <= l_mem[cmd.l_addr];
    end
  end

  // Working registers of the elimination.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      ilu_pkg::OP_SETA: a_r <= u_rd_r;
      ilu_pkg::OP_SETB: begin
        b_r <= u_rd_r;
        x_r <= a_r;
        y_r <= u_rd_r;
      end
      ilu_pkg::OP_GNEXT: begin
        x_r <= y_r;
        y_r <= div_rem;
      end
      ilu_pkg::OP_PROD:  prod_r <= ilu_pkg::UW'(a_r * b_r);
      ilu_pkg::OP_LSET:  lcm_r  <= div_quo[ilu_pkg::UW-1:0];
      ilu_pkg::OP_M1SET: mul1_r <= div_quo[ilu_pkg::UW-1:0];
      ilu_pkg::OP_M2SET: mul2_r <= div_quo[ilu_pkg::UW-1:0];
      ilu_pkg::OP_URDT:  t_r    <= u_rd_r;
      ilu_pkg::OP_UMUL:  e_r    <= ilu_pkg::UW'(mul2_r * u_rd_r);
      ilu_pkg::OP_LMSET: lv_r   <= mul_res;
      default: ;
    endcase
  end

  // Result registers; read data arrives in the cycle after the read command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= (cmd.op == ilu_pkg::OP_OUT) || (cmd.op == ilu_pkg::OP_FAIL);
    end
    orow_r  <= cmd.orow;
    ocol_r  <= cmd.ocol;
    ml_r    <= cmd.ml;
    mu_r    <= cmd.mu;
    olast_r <= cmd.olast;
    ost_r   <= cmd.op == ilu_pkg::OP_FAIL;
  end

  assign stat.div_done  = div_done;
  assign stat.mul_done  = mul_done;
  assign stat.rd_zero   = u_rd_r == '0;
  assign stat.y_zero    = y_r == '0;
  assign stat.mul2_zero = mul2_r == '0;

  assign out_strobe      = ov_r;
  assign out_row         = orow_r;
  assign out_col         = ocol_r;
  assign out_lower_value = ml_r ? l_rd_r : '0;
  assign out_upper_value = mu_r ? u_rd_r : '0;
  assign out_status      = ost_r;
  assign out_last        = olast_r;

endmodule

### rtl/ilu_ctrl.sv
// Controller: load counters, elimination loop sequencer and result sequencer.
module ilu_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            cfg_we,
  input  logic [ilu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ilu_pkg::CFG_W-1:0]       cfg_wdata,
  output ilu_pkg::cmd_t                   cmd,
  input  ilu_pkg::stat_t                  stat
);

  ilu_pkg::state_t state_r, state_nxt;
  logic [ilu_pkg::CNT_W-1:0]  m_r, m_nxt, n_r, n_nxt;
  logic [ilu_pkg::CNT_W-1:0]  p_r, p_nxt, k_r, k_nxt, r_r, r_nxt, c_r, c_nxt;
  logic [ilu_pkg::ADDR_W-1:0] i_r, i_nxt;
  logic [ilu_pkg::CNT_W-1:0]  w;
  logic [ilu_pkg::CNT_W-1:0]  p_inc;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ilu_pkg::S_IDLE;
      m_r     <= ilu_pkg::CNT_W'(ilu_pkg::MAX_DIM);
      n_r     <= ilu_pkg::CNT_W'(ilu_pkg::MAX_DIM);
      p_r     <= '0;
      k_r     <= '0;
      r_r     <= '0;
      c_r     <= '0;
      i_r     <= '0;
    end else begin
      state_r <= state_nxt;
      m_r     <= m_nxt;
      n_r     <= n_nxt;
      p_r     <= p_nxt;
      k_r     <= k_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      i_r     <= i_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    n_nxt     = n_r;
    p_nxt     = p_r;
    k_nxt     = k_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    i_nxt     = i_r;
    w         = (m_r > n_r) ? m_r : n_r;
    p_inc     = p_r + ilu_pkg::CNT_W'(1);
    cmd       = '0;
    cmd.op    = ilu_pkg::OP_NONE;
    busy      = state_r != ilu_pkg::S_IDLE;

    unique case (state_r)
      ilu_pkg::S_IDLE: begin
        // Each transfer writes the next entry in row-major order.
        if (start) begin
          cmd.op     = ilu_pkg::OP_LOAD;
          cmd.u_addr = ilu_pkg::addr_of(r_r, c_r);
          if (c_r == n_r - ilu_pkg::CNT_W'(1)) begin
            c_nxt = '0;
            if (r_r == m_r - ilu_pkg::CNT_W'(1)) begin
              r_nxt     = '0;
              i_nxt     = '0;
              state_nxt = ilu_pkg::S_LINIT;
            end else begin
              r_nxt = r_r + ilu_pkg::CNT_W'(1);
            end
          end else begin
            c_nxt = c_r + ilu_pkg::CNT_W'(1);
          end
        end
      end
      ilu_pkg::S_LINIT: begin
        // Sweep L to the identity.
        cmd.op     = ilu_pkg::OP_LINIT;
        cmd.l_addr = i_r;
        cmd.diag   = (i_r[ilu_pkg::ADDR_W-1:ilu_pkg::DIM_W] == i_r[ilu_pkg::DIM_W-1:0]) &&
                     ({1'b0, i_r[ilu_pkg::ADDR_W-1:ilu_pkg::DIM_W]} < m_r);
        i_nxt      = i_r + ilu_pkg::ADDR_W'(1);
        if (i_r == ilu_pkg::ADDR_W'(ilu_pkg::DEPTH - 1)) begin
          p_nxt     = '0;
          state_nxt = ilu_pkg::S_PSTART;
        end
      end
      ilu_pkg::S_PSTART: begin
        if (p_r < m_r && p_r < n_r) begin
          cmd.op     = ilu_pkg::OP_URD;
          cmd.u_addr = ilu_pkg::addr_of(p_r, p_r);
          state_nxt  = ilu_pkg::S_PCHK;
        end else begin
          r_nxt     = '0;
          c_nxt     = '0;
          state_nxt = ilu_pkg::S_ORD;
        end
      end
      ilu_pkg::S_PCHK: begin
        cmd.op    = ilu_pkg::OP_SETA;
        k_nxt     = p_inc;
        state_nxt = stat.rd_zero ? ilu_pkg::S_ZNEXT : ilu_pkg::S_KNEXT;
      end
      ilu_pkg::S_ZNEXT: begin
        // Zero pivot: any nonzero entry below it needs a row exchange.
        if (k_r < m_r) begin
          cmd.op     = ilu_pkg::OP_URD;
          cmd.u_addr = ilu_pkg::addr_of(k_r, p_r);
          state_nxt  = ilu_pkg::S_ZCHK;
        end else begin
          p_nxt     = p_inc;
          state_nxt = ilu_pkg::S_PSTART;
        end
      end
      ilu_pkg::S_ZCHK: begin
        if (!stat.rd_zero) begin
          cmd.op    = ilu_pkg::OP_FAIL;
          cmd.olast = 1'b1;
          r_nxt     = '0;
          c_nxt     = '0;
          state_nxt = ilu_pkg::S_IDLE;
        end else begin
          k_nxt     = k_r + ilu_pkg::CNT_W'(1);
          state_nxt = ilu_pkg::S_ZNEXT;
        end
      end
      ilu_pkg::S_KNEXT: begin
        if (k_r < m_r) begin
          cmd.op     = ilu_pkg::OP_URD;
          cmd.u_addr = ilu_pkg::addr_of(k_r, p_r);
          state_nxt  = ilu_pkg::S_BCHK;
        end else begin
          p_nxt     = p_inc;
          state_nxt = ilu_pkg::S_PSTART;
        end
      end
      ilu_pkg::S_BCHK: begin
        if (stat.rd_zero) begin
          k_nxt     = k_r + ilu_pkg::CNT_W'(1);
          state_nxt = ilu_pkg::S_KNEXT;
        end else begin
          cmd.op    = ilu_pkg::OP_SETB;
          state_nxt = ilu_pkg::S_GCHK;
        end
      end
      ilu_pkg::S_GWAIT: begin
        if (stat.div_done) begin
          cmd.op    = ilu_pkg::OP_GNEXT;
          state_nxt = ilu_pkg::S_GCHK;
        end
      end
      ilu_pkg::S_GCHK: begin
        // Euclid: divide again until the remainder is zero.
        if (stat.y_zero) begin
          cmd.op    = ilu_pkg::OP_PROD;
          state_nxt = ilu_pkg::S_LSTART;
        end else begin
          cmd.op    = ilu_pkg::OP_GSTART;
          state_nxt = ilu_pkg::S_GWAIT;
        end
      end
      ilu_pkg::S_LSTART: begin
        cmd.op    = ilu_pkg::OP_LSTART;
        state_nxt = ilu_pkg::S_LWAIT;
      end
      ilu_pkg::S_LWAIT: begin
        if (stat.div_done) begin
          cmd.op    = ilu_pkg::OP_LSET;
          state_nxt = ilu_pkg::S_M1S;
        end
      end
      ilu_pkg::S_M1S: begin
        cmd.op    = ilu_pkg::OP_M1START;
        state_nxt = ilu_pkg::S_M1W;
      end
      ilu_pkg::S_M1W: begin
        if (stat.div_done) begin
          cmd.op    = ilu_pkg::OP_M1SET;
          state_nxt = ilu_pkg::S_M2S;
        end
      end
      ilu_pkg::S_M2S: begin
        cmd.op    = ilu_pkg::OP_M2START;
        state_nxt = ilu_pkg::S_M2W;
      end
      ilu_pkg::S_M2W: begin
        if (stat.div_done) begin
          cmd.op    = ilu_pkg::OP_M2SET;
          c_nxt     = '0;
          state_nxt = ilu_pkg::S_RUP;
        end
      end
      ilu_pkg::S_RUP: begin
        // Row update, one column per pass through S_RUP, S_RUK, S_RUM and S_RUW.
        if (c_r < n_r) begin
          cmd.op     = ilu_pkg::OP_URD;
          cmd.u_addr = ilu_pkg::addr_of(p_r, c_r);
          state_nxt  = ilu_pkg::S_RUK;
        end else begin
          r_nxt     = '0;
          state_nxt = stat.mul2_zero ? ilu_pkg::S_LM : ilu_pkg::S_LD;
        end
      end
      ilu_pkg::S_RUK: begin
        cmd.op     = ilu_pkg::OP_URDT;
        cmd.u_addr = ilu_pkg::addr_of(k_r, c_r);
        state_nxt  = ilu_pkg::S_RUM;
      end
      ilu_pkg::S_RUM: begin
        cmd.op    = ilu_pkg::OP_UMUL;
        state_nxt = ilu_pkg::S_RUW;
      end
      ilu_pkg::S_RUW: begin
        cmd.op     = ilu_pkg::OP_UWR;
        cmd.u_addr = ilu_pkg::addr_of(k_r, c_r);
        c_nxt      = c_r + ilu_pkg::CNT_W'(1);
        state_nxt  = ilu_pkg::S_RUP;
      end
      ilu_pkg::S_LD: begin
        // Column k of L divided by mul2.
        if (r_r < m_r) begin
          cmd.op     = ilu_pkg::OP_LRD;
          cmd.l_addr = ilu_pkg::addr_of(r_r, k_r);
          state_nxt  = ilu_pkg::S_LDS;
        end else begin
          r_nxt     = '0;
          state_nxt = ilu_pkg::S_LM;
        end
      end
      ilu_pkg::S_LDS: begin
        cmd.op    = ilu_pkg::OP_LDSTART;
        state_nxt = ilu_pkg::S_LDW;
      end
      ilu_pkg::S_LDW: begin
        if (stat.div_done) begin
          cmd.op     = ilu_pkg::OP_LDWR;
          cmd.l_addr = ilu_pkg::addr_of(r_r, k_r);
          r_nxt      = r_r + ilu_pkg::CNT_W'(1);
          state_nxt  = ilu_pkg::S_LD;
        end
      end
      ilu_pkg::S_LM: begin
        // Column p of L gains mul1 times column k.
        if (r_r < m_r) begin
          cmd.op     = ilu_pkg::OP_LRD;
          cmd.l_addr = ilu_pkg::addr_of(r_r, k_r);
          state_nxt  = ilu_pkg::S_LMS;
        end else begin
          k_nxt     = k_r + ilu_pkg::CNT_W'(1);
          state_nxt = ilu_pkg::S_KNEXT;
        end
      end
      ilu_pkg::S_LMS: begin
        cmd.op    = ilu_pkg::OP_LMSTART;
        state_nxt = ilu_pkg::S_LMW;
      end
      ilu_pkg::S_LMW: begin
        if (stat.mul_done) begin
          cmd.op     = ilu_pkg::OP_LMSET;
          cmd.l_addr = ilu_pkg::addr_of(r_r, p_r);
          state_nxt  = ilu_pkg::S_LAW;
        end
      end
      ilu_pkg::S_LAW: begin
        cmd.op     = ilu_pkg::OP_LAWR;
        cmd.l_addr = ilu_pkg::addr_of(r_r, p_r);
        r_nxt      = r_r + ilu_pkg::CNT_W'(1);
        state_nxt  = ilu_pkg::S_LM;
      end
      ilu_pkg::S_ORD: begin
        // One result read per cycle, row-major.
        cmd.op     = ilu_pkg::OP_OUT;
        cmd.u_addr = ilu_pkg::addr_of(r_r, c_r);
        cmd.l_addr = ilu_pkg::addr_of(r_r, c_r);
        cmd.orow   = r_r[ilu_pkg::DIM_W-1:0];
        cmd.ocol   = c_r[ilu_pkg::DIM_W-1:0];
        cmd.ml     = c_r < m_r;
        cmd.mu     = c_r < n_r;
        cmd.olast  = (r_r == m_r - ilu_pkg::CNT_W'(1)) && (c_r == w - ilu_pkg::CNT_W'(1));
        if (c_r == w - ilu_pkg::CNT_W'(1)) begin
          c_nxt = '0;
          if (r_r == m_r - ilu_pkg::CNT_W'(1)) begin
            r_nxt     = '0;
            state_nxt = ilu_pkg::S_IDLE;
          end else begin
            r_nxt = r_r + ilu_pkg::CNT_W'(1);
          end
        end else begin
          c_nxt = c_r + ilu_pkg::CNT_W'(1);
        end
      end
      default: state_nxt = ilu_pkg::S_IDLE;
    endcase

    // A register write restarts loading.
    if (cfg_we) begin
      r_nxt = '0;
      c_nxt = '0;
      unique case (cfg_index)
        ilu_pkg::REG_ROW_COUNT:    m_nxt = ilu_pkg::clamp_dim(cfg_wdata);
        ilu_pkg::REG_COLUMN_COUNT: n_nxt = ilu_pkg::clamp_dim(cfg_wdata);
        default: ;
      endcase
    end
  end

endmodule

### tb/integer_lu_factorizer_core_tb.sv
// Self-checking testbench of the integer LU factorizer core with its own factorization predictor.
module integer_lu_factorizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SAT_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic [ilu_pkg::DIM_W-1:0] row;
    logic [ilu_pkg::DIM_W-1:0] col;
    longint                    lower_value;
    int                        upper_value;
    logic                      status;
    logic                      last;
  } lu_entry_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic signed [ilu_pkg::UW-1:0]       in_element = '0;
  logic                                cfg_we = 1'b0;
  logic [ilu_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [ilu_pkg::CFG_W-1:0]           cfg_wdata = '0;
  logic                                out_strobe;
  logic [ilu_pkg::DIM_W-1:0]           out_row;
  logic [ilu_pkg::DIM_W-1:0]           out_col;
  logic signed [ilu_pkg::LW-1:0]       out_lower_value;
  logic signed [ilu_pkg::UW-1:0]       out_upper_value;
  logic                                out_status;
  logic                                out_last;

  integer_lu_factorizer_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_element(in_element),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_row(out_row), .out_col(out_col),
    .out_lower_value(out_lower_value), .out_upper_value(out_upper_value),
    .out_status(out_status), .out_last(out_last)
  );

  // Shadow of the block state.
  int        u_mat [ilu_pkg::DEPTH];
  longint    l_mat [ilu_pkg::DEPTH];
  int        elem_pos;
  int        rows_m;
  int        cols_n;

  int        pending_elems [$];
  lu_entry_t lu_expected [$];
  int        send_idle_pct;
  int        items_sent;
  bit        failed;

  // Clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int clamp_size(logic [ilu_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > ilu_pkg::MAX_DIM) return ilu_pkg::MAX_DIM;
    return v;
  endfunction

  function automatic int div32(int a, int b);
    if (b == 0) return 0;
    if (a == 32'sh8000_0000 && b == -1) return a;
    return a / b;
  endfunction

  function automatic int rem32(int a, int b);
    if (b == 0 || b == -1) return 0;
    return a % b;
  endfunction

  function automatic int gcd32(int x, int y);
    int r;
    while (y != 0) begin
      r = rem32(x, y);
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic longint add_sat(longint a, longint b);
    if (b > 0 && a > SAT_MAX - b) return SAT_MAX;
    if (b < 0 && a < SAT_MIN - b) return SAT_MIN;
    return a + b;
  endfunction

  function automatic longint mul_sat(longint v, int m);
    bit                neg;
    longint unsigned   a;
    longint unsigned   b;
    longint unsigned   lim;
    longint unsigned   p;
    neg = (v < 0) != (m < 0);
    a = (v < 0) ? longint'(-(v + 1)) + 1 : v;
    b = (m < 0) ? -longint'(m) : longint'(m);
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (b != 0 && a > lim / b) return neg ? SAT_MIN : SAT_MAX;
    p = a * b;
    if (!neg) return p;
    if (p == 64'h8000_0000_0000_0000) return SAT_MIN;
    return -longint'(p);
  endfunction

  // Elimination without row exchange; returns 0 when a zero pivot has a nonzero below it.
  function automatic bit factorize();
    int a, b, g, lcm, mul1, mul2;
    for (int r = 0; r < ilu_pkg::DEPTH; r++) l_mat[r] = 0;
    for (int r = 0; r < rows_m; r++) l_mat[r * ilu_pkg::MAX_DIM + r] = ilu_pkg::Q_ONE;
    for (int p = 0; p < rows_m && p < cols_n; p++) begin
      a = u_mat[p * ilu_pkg::MAX_DIM + p];
      if (a == 0) begin
        for (int k = p + 1; k < rows_m; k++)
          if (u_mat[k * ilu_pkg::MAX_DIM + p] != 0) return 1'b0;
        continue;
      end
      for (int k = p + 1; k < rows_m; k++) begin
        b = u_mat[k * ilu_pkg::MAX_DIM + p];
        if (b == 0) continue;
        g = gcd32(a, b);
        lcm = div32(a * b, g);
        mul1 = div32(lcm, a);
        mul2 = div32(lcm, b);
        for (int c = 0; c < cols_n; c++)
          u_mat[k * ilu_pkg::MAX_DIM + c] = mul2 * u_mat[k * ilu_pkg::MAX_DIM + c] -
                                            mul1 * u_mat[p * ilu_pkg::MAX_DIM + c];
        if (mul2 != 0) begin
          for (int r = 0; r < rows_m; r++) begin
            if (l_mat[r * ilu_pkg::MAX_DIM + k] == SAT_MIN && mul2 == -1)
              l_mat[r * ilu_pkg::MAX_DIM + k] = SAT_MAX;
            else
              l_mat[r * ilu_pkg::MAX_DIM + k] = l_mat[r * ilu_pkg::MAX_DIM + k] /
                                                longint'(mul2);
          end
        end
        for (int r = 0; r < rows_m; r++)
          l_mat[r * ilu_pkg::MAX_DIM + p] =
            add_sat(l_mat[r * ilu_pkg::MAX_DIM + p],
                    mul_sat(l_mat[r * ilu_pkg::MAX_DIM + k], mul1));
      end
    end
    return 1'b1;
  endfunction

  // Store one element; on the last one of the matrix queue the factors it yields.
  function automatic void load_element(int value);
    lu_entry_t e;
    int        span;
    if (elem_pos >= rows_m * cols_n) elem_pos = 0;
    u_mat[(elem_pos / cols_n) * ilu_pkg::MAX_DIM + (elem_pos % cols_n)] = value;
    elem_pos++;
    if (elem_pos < rows_m * cols_n) return;
    elem_pos = 0;
    if (!factorize()) begin
      e = '{row: '0, col: '0, lower_value: 0, upper_value: 0, status: 1'b1, last: 1'b1};
      lu_expected.insert(lu_expected.size(), e);
      return;
    end
    span = rows_m > cols_n ? rows_m : cols_n;
    for (int r = 0; r < rows_m; r++) begin
      for (int c = 0; c < span; c++) begin
        e.row = ilu_pkg::DIM_W'(r);
        e.col = ilu_pkg::DIM_W'(c);
        e.lower_value = c < rows_m ? l_mat[r * ilu_pkg::MAX_DIM + c] : 0;
        e.upper_value = c < cols_n ? u_mat[r * ilu_pkg::MAX_DIM + c] : 0;
        e.status = 1'b0;
        e.last = (r == rows_m - 1) && (c == span - 1);
        lu_expected.insert(lu_expected.size(), e);
      end
    end
  endfunction

  // Driver: presents pending elements and holds each one until its transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        load_element(pending_elems.pop_front());
      end
      if (!(start && busy)) begin
        if (pending_elems.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          start <= 1'b1;
          in_element <= pending_elems[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    lu_entry_t e;
    if (rst_n && out_strobe) begin
      if (lu_expected.size() == 0) begin
        $error("unexpected result row=%0d col=%0d", out_row, out_col);
        failed = 1'b1;
      end else begin
        e = lu_expected.pop_front();
        if (out_row !== e.row) begin
          $error("row: expected %0d, actual %0d", e.row, out_row);
          failed = 1'b1;
        end
        if (out_col !== e.col) begin
          $error("col: expected %0d, actual %0d", e.col, out_col);
          failed = 1'b1;
        end
        if (out_lower_value !== e.lower_value) begin
          $error("lower_value: expected %0d, actual %0d", e.lower_value, out_lower_value);
          failed = 1'b1;
        end
        if (out_upper_value !== e.upper_value) begin
          $error("upper_value: expected %0d, actual %0d", e.upper_value, out_upper_value);
          failed = 1'b1;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_status);
          failed = 1'b1;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d, actual %0d", e.last, out_last);
          failed = 1'b1;
        end
      end
    end
  end

  // Waits until every element has transferred and every expected result has come.
  task automatic drain();
    do @(posedge clk);
    while (pending_elems.size() != 0 || start || busy || lu_expected.size() != 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [ilu_pkg::CFG_IDX_W-1:0] idx,
                           logic [ilu_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ilu_pkg::REG_ROW_COUNT) rows_m = clamp_size(value);
    else cols_n = clamp_size(value);
    elem_pos = 0;
  endtask

  task automatic set_shape(int m, int n);
    drain();
    write_reg(ilu_pkg::REG_ROW_COUNT, ilu_pkg::CFG_W'(m));
    write_reg(ilu_pkg::REG_COLUMN_COUNT, ilu_pkg::CFG_W'(n));
  endtask

  function automatic int random_element();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return $urandom_range(0, 18) - 9;
    if (pick < 65) return 0;
    if (pick < 78) return $urandom;
    if (pick < 90) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return -1;
        default: return 1;
      endcase
    end
    return $urandom_range(0, 65535) - 32768;
  endfunction

  task automatic push_matrix(int count);
    for (int i = 0; i < count; i++) begin
      pending_elems.insert(pending_elems.size(), random_element());
      items_sent++;
    end
  endtask

  // Stimulus.
  initial begin
    failed = 1'b0;
    items_sent = 0;
    send_idle_pct = 26;
    for (int i = 0; i < ilu_pkg::DEPTH; i++) begin
      u_mat[i] = 0;
      l_mat[i] = 0;
    end
    elem_pos = 0;
    rows_m = 4;
    cols_n = 4;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Full 4x4 at reset size with the extreme values.
    pending_elems = '{32'sh7FFF_FFFF, 2, 3, -1, 32'sh8000_0000, 5, 0, 7,
                      4, -6, 32'sh8000_0000, 1, -1, 32'sh7FFF_FFFF, 9, -3};
    items_sent += pending_elems.size();
    // Zero pivot with a nonzero entry below it needs a row exchange.
    set_shape(2, 2);
    pending_elems = '{0, 1, 1, 0};
    items_sent += pending_elems.size();
    // A partly loaded matrix is abandoned by a register write.
    drain();
    pending_elems = '{5, 6};
    items_sent += pending_elems.size();
    // Out-of-range values: zero becomes one row, seven becomes the maximum.
    set_shape(0, 7);
    pending_elems = '{3, -4, 0, 8};
    items_sent += pending_elems.size();
    // A single column: one pivot for every row operation; L still has one column per row.
    set_shape(7, 1);
    pending_elems = '{6, -4, 9, 0};
    items_sent += pending_elems.size();

    // Random matrices; phases change the sender's idle rate.
    while (items_sent < 180) begin
      send_idle_pct = items_sent < 60 ? 26 : (items_sent < 120 ? 54 : 0);
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 7) == 0) push_matrix($urandom_range(1, rows_m * cols_n - 1));
        set_shape($urandom_range(0, 4) == 0 ? 4 : $urandom_range(1, 3),
                  $urandom_range(0, 4) == 0 ? 4 : $urandom_range(1, 3));
      end
      push_matrix(rows_m * cols_n);
    end

    drain();
    if (failed) begin
      $display("integer_lu_factorizer_core_tb: done, errors");
    end else begin
      $display("integer_lu_factorizer_core_tb: done, clean");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #100ms;
    $display("integer_lu_factorizer_core_tb: done, errors");
    $finish;
  end

endmodule
